// ----- sv/rled_pkg.sv -----
// rled_pkg: shared types and constants for the run list extent decoder.
// Holds channel payload structs, status codes and the front-to-back command word.
// No dependencies.
package rled_pkg;

   localparam int MAX_FIELD_BYTES = 8;
   localparam int CLUSTER_W       = 22;
   localparam logic [CLUSTER_W-1:0] CLUSTER_RESET = 22'd4096;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = 3;

   typedef enum logic {
      KIND_EXTENT = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_HEADER = 3'd1,
      ST_TRUNCATED  = 3'd2,
      ST_SPARSE     = 3'd3,
      ST_NEGATIVE   = 3'd4,
      ST_EMPTY      = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] run_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [63:0] disk_offset;
      logic [63:0] length_bytes;
      status_type  status;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      kind_type    kind;
      logic        trail_ok;
      logic [62:0] cluster;
      logic [63:0] run_length;
      status_type  status;
   } cmd_type;

endpackage

// ----- sv/rled_front.sv -----
// rled_front: byte-wise run list parser; gathers fields, tracks the cluster number.
// Emits one command word per finished run or list end into the queue.
// Depends on rled_pkg.
module rled_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  rled_pkg::req_type req_data,
   output logic              push,
   output rled_pkg::cmd_type push_cmd
);

   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_LENGTH = 4'b0010,
      PH_OFFSET = 4'b0100,
      PH_ENDED  = 4'b1000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  len_size_ff, len_size_in;
   logic [3:0]  off_size_ff, off_size_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [63:0] run_len_ff, run_len_in;
   logic [63:0] delta_ff, delta_in;
   logic [63:0] cluster_ff, cluster_in;
   logic        any_ff, any_in;

   logic [7:0]  b;
   logic        last;
   logic [3:0]  cnt_inc;
   logic [63:0] ins;
   logic [63:0] delta_full;
   logic [63:0] sum;
   logic [3:0]  ls, os;
   logic        cmd_push;
   logic [3:0]  max_sz;

   assign b       = req_data.run_byte;
   assign last    = req_data.last_byte;
   assign cnt_inc = cnt_ff + 4'd1;
   assign ins     = {56'd0, b} << {cnt_ff[2:0], 3'b000};
   assign ls      = b[3:0];
   assign os      = b[7:4];
   assign max_sz  = 4'(rled_pkg::MAX_FIELD_BYTES);

   always_comb begin
      phase_in    = phase_ff;
      len_size_in = len_size_ff;
      off_size_in = off_size_ff;
      cnt_in      = cnt_ff;
      run_len_in  = run_len_ff;
      delta_in    = delta_ff;
      cluster_in  = cluster_ff;
      any_in      = any_ff;
      cmd_push    = 1'b0;
      push_cmd.kind       = rled_pkg::KIND_STATUS;
      push_cmd.trail_ok   = 1'b0;
      push_cmd.cluster    = cluster_ff[62:0];
      push_cmd.run_length = run_len_ff;
      push_cmd.status     = rled_pkg::ST_OK;
      delta_full = delta_ff | ins;
      if (b[7] && (off_size_ff < max_sz)) begin
         delta_full = delta_full | (~64'd0 << {off_size_ff[2:0], 3'b000});
      end
      sum = cluster_ff + delta_full;

      case (phase_ff)
         PH_HEADER: begin
            if (b == 8'd0) begin
               cmd_push        = 1'b1;
               push_cmd.status = any_ff ? rled_pkg::ST_OK : rled_pkg::ST_EMPTY;
               phase_in        = PH_ENDED;
            end else if ((ls == 4'd0) || (ls > max_sz) || (os > max_sz)) begin
               cmd_push        = 1'b1;
               push_cmd.status = rled_pkg::ST_BAD_HEADER;
               phase_in        = PH_ENDED;
            end else if (last) begin
               cmd_push        = 1'b1;
               push_cmd.status = rled_pkg::ST_TRUNCATED;
               phase_in        = PH_ENDED;
            end else begin
               len_size_in = ls;
               off_size_in = os;
               cnt_in      = 4'd0;
               run_len_in  = 64'd0;
               delta_in    = 64'd0;
               phase_in    = PH_LENGTH;
            end
         end
         PH_LENGTH: begin
            run_len_in = run_len_ff | ins;
            cnt_in     = cnt_inc;
            if (cnt_inc >= len_size_ff) begin
               if (off_size_ff == 4'd0) begin
                  cmd_push        = 1'b1;
                  push_cmd.status = rled_pkg::ST_SPARSE;
                  phase_in        = PH_ENDED;
               end else if (last) begin
                  cmd_push        = 1'b1;
                  push_cmd.status = rled_pkg::ST_TRUNCATED;
                  phase_in        = PH_ENDED;
               end else begin
                  cnt_in   = 4'd0;
                  phase_in = PH_OFFSET;
               end
            end else if (last) begin
               cmd_push        = 1'b1;
               push_cmd.status = rled_pkg::ST_TRUNCATED;
               phase_in        = PH_ENDED;
            end
         end
         PH_OFFSET: begin
            delta_in = delta_ff | ins;
            cnt_in   = cnt_inc;
            if (cnt_inc >= off_size_ff) begin
               delta_in   = delta_full;
               cluster_in = sum;
               cmd_push   = 1'b1;
               if (sum[63]) begin
                  push_cmd.status = rled_pkg::ST_NEGATIVE;
                  phase_in        = PH_ENDED;
               end else begin
                  push_cmd.kind     = rled_pkg::KIND_EXTENT;
                  push_cmd.trail_ok = last;
                  push_cmd.cluster  = sum[62:0];
                  any_in            = 1'b1;
                  cnt_in            = 4'd0;
                  phase_in          = last ? PH_ENDED : PH_HEADER;
               end
            end else if (last) begin
               cmd_push        = 1'b1;
               push_cmd.status = rled_pkg::ST_TRUNCATED;
               phase_in        = PH_ENDED;
            end
         end
         default: begin
         end
      endcase

      if (last) begin
         phase_in    = PH_HEADER;
         len_size_in = 4'd0;
         off_size_in = 4'd0;
         cnt_in      = 4'd0;
         run_len_in  = 64'd0;
         delta_in    = 64'd0;
         cluster_in  = 64'd0;
         any_in      = 1'b0;
      end
   end

   assign push = accept && cmd_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         len_size_ff <= 4'd0;
         off_size_ff <= 4'd0;
         cnt_ff      <= 4'd0;
         run_len_ff  <= 64'd0;
         delta_ff    <= 64'd0;
         cluster_ff  <= 64'd0;
         any_ff      <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         len_size_ff <= len_size_in;
         off_size_ff <= off_size_in;
         cnt_ff      <= cnt_in;
         run_len_ff  <= run_len_in;
         delta_ff    <= delta_in;
         cluster_ff  <= cluster_in;
         any_ff      <= any_in;
      end
   end

endmodule

// ----- sv/rled_queue.sv -----
// rled_queue: short command FIFO between parser and extent multiplier.
// Depends on rled_pkg.
module rled_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rled_pkg::cmd_type push_cmd,
   input  logic              pop,
   output rled_pkg::cmd_type head_cmd,
   output logic              empty,
   output logic              full
);

   rled_pkg::cmd_type entry_ff [rled_pkg::QUEUE_DEPTH];
   logic [rled_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rled_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rled_pkg::QUEUE_CW-1:0] count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == rled_pkg::QUEUE_CW'(rled_pkg::QUEUE_DEPTH));
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + rled_pkg::QUEUE_CW'(push) - rled_pkg::QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- sv/rled_back.sv -----
// rled_back: scales cluster number and run length by the cluster size.
// Split 32x22 partial products, one register stage, then the result register.
// Depends on rled_pkg.
module rled_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [rled_pkg::CLUSTER_W-1:0]    cluster_bytes,
   input  logic                              q_empty,
   input  rled_pkg::cmd_type                 q_head,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output rled_pkg::rsp_type                 rsp_data
);

   logic              m_valid_ff, m_valid_in;
   rled_pkg::kind_type   m_kind_ff, m_kind_in;
   logic              m_trail_ff, m_trail_in;
   rled_pkg::status_type m_status_ff, m_status_in;
   logic [53:0]       off_lo_ff, off_lo_in;
   logic [31:0]       off_hi_ff, off_hi_in;
   logic [53:0]       len_lo_ff, len_lo_in;
   logic [31:0]       len_hi_ff, len_hi_in;

   logic              out_valid_ff, out_valid_in;
   rled_pkg::rsp_type out_ff, out_in;

   logic              out_free;
   logic              m_split;
   logic              m_move;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign m_split  = (m_kind_ff == rled_pkg::KIND_EXTENT) && m_trail_ff;
   assign m_move   = m_valid_ff && out_free;
   assign q_pop    = !q_empty && (!m_valid_ff || (m_move && !m_split));

   always_comb begin
      off_lo_in = 54'(q_head.cluster[31:0]) * 54'(cluster_bytes);
      off_hi_in = 32'({1'b0, q_head.cluster[62:32]} * 32'(cluster_bytes));
      len_lo_in = 54'(q_head.run_length[31:0]) * 54'(cluster_bytes);
      len_hi_in = 32'(q_head.run_length[63:32] * 32'(cluster_bytes));

      m_valid_in  = m_valid_ff;
      m_kind_in   = m_kind_ff;
      m_trail_in  = m_trail_ff;
      m_status_in = m_status_ff;
      if (q_pop) begin
         m_valid_in  = 1'b1;
         m_kind_in   = q_head.kind;
         m_trail_in  = q_head.trail_ok;
         m_status_in = q_head.status;
      end else if (m_move && m_split) begin
         // hold the stage: closing ok status follows the extent
         m_kind_in   = rled_pkg::KIND_STATUS;
         m_trail_in  = 1'b0;
         m_status_in = rled_pkg::ST_OK;
      end else if (m_move) begin
         m_valid_in = 1'b0;
      end

      out_in.result_kind = m_kind_ff;
      out_in.status      = m_status_ff;
      if (m_kind_ff == rled_pkg::KIND_EXTENT) begin
         out_in.disk_offset  = 64'(off_lo_ff) + {off_hi_ff, 32'd0};
         out_in.length_bytes = 64'(len_lo_ff) + {len_hi_ff, 32'd0};
         out_in.status       = rled_pkg::ST_OK;
         out_in.last_result  = !m_trail_ff;
      end else begin
         out_in.disk_offset  = 64'd0;
         out_in.length_bytes = 64'd0;
         out_in.last_result  = 1'b1;
      end

      out_valid_in = out_free ? m_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         off_lo_ff <= off_lo_in;
         off_hi_ff <= off_hi_in;
         len_lo_ff <= len_lo_in;
         len_hi_ff <= len_hi_in;
      end
      if (m_move) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         m_kind_ff    <= rled_pkg::KIND_STATUS;
         m_trail_ff   <= 1'b0;
         m_status_ff  <= rled_pkg::ST_OK;
         out_valid_ff <= 1'b0;
      end else begin
         m_valid_ff   <= m_valid_in;
         m_kind_ff    <= m_kind_in;
         m_trail_ff   <= m_trail_in;
         m_status_ff  <= m_status_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.result_kind == rled_pkg::KIND_STATUS) |->
      (out_ff.disk_offset == 64'd0 && out_ff.length_bytes == 64'd0 && out_ff.last_result))
      else $error("status result carries extent data");

   a_split_holds: assert property (@(posedge clock) disable iff (reset)
      (m_move && m_split) |=> (m_valid_ff && m_kind_ff == rled_pkg::KIND_STATUS))
      else $error("closing status lost after final extent");

   a_pending_close: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.result_kind == rled_pkg::KIND_EXTENT && !out_ff.last_result)
      |-> m_valid_ff)
      else $error("extent without pending closing status");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty queue");

endmodule

// ----- sv/run_list_extent_decoder.sv -----
// run_list_extent_decoder: top level; cluster size register, parser, queue, scaler.
// Depends on rled_pkg, rled_front, rled_queue, rled_back.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | rled_pkg::req_type (one run list byte)
//   rsp     | out       | rsp_valid/rsp_stall  | rled_pkg::rsp_type (extent or status)
//   csr     | in        | csr_write_enable     | cluster_bytes, 22 bits
//
// One byte accepted per cycle unless req_stall; a byte gives zero, one or two results.
// Results pass the command queue, scaler stage and output register; an extent
// closing the list yields two results (extent, then ok status) at the output.
// req_stall rises only when the four-entry command queue is full.
// Synchronous reset clears parser state and sets cluster_bytes to 4096.
module run_list_extent_decoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  rled_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output rled_pkg::rsp_type              rsp_data,
   input  logic                           csr_write_enable,
   input  logic [rled_pkg::CLUSTER_W-1:0] csr_write_data
);

   logic [rled_pkg::CLUSTER_W-1:0] cluster_bytes_ff;
   logic                           accept;
   logic                           push;
   rled_pkg::cmd_type              push_cmd;
   logic                           pop;
   rled_pkg::cmd_type              head_cmd;
   logic                           q_empty;
   logic                           q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_bytes_ff <= rled_pkg::CLUSTER_RESET;
      end else if (csr_write_enable) begin
         cluster_bytes_ff <= csr_write_data;
      end
   end

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   rled_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .push     (push),
      .push_cmd (push_cmd)
   );

   rled_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (q_empty),
      .full     (q_full)
   );

   rled_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cluster_bytes (cluster_bytes_ff),
      .q_empty       (q_empty),
      .q_head        (head_cmd),
      .q_pop         (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

endmodule

// ----- tb/sv/tb_run_list_extent_decoder.sv -----
// Testbench for run_list_extent_decoder: drives packed run lists byte by byte and
// checks every extent and status word against an in-bench decoder or directed rows.
// Depends on rled_pkg and the run_list_extent_decoder RTL.
module tb_run_list_extent_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_WORDS = 300;
   localparam int HOLD_AFTER  = 700;

   typedef enum logic [1:0] {
      SEEK_HEADER,
      IN_LENGTH,
      IN_OFFSET,
      LIST_DONE
   } parse_phase_type;

   typedef struct {
      rled_pkg::req_type word;
      int                typed;
      rled_pkg::rsp_type first;
      rled_pkg::rsp_type second;
   } directed_row_type;

   logic                           clock;
   logic                           reset            = 1'b1;
   logic                           req_valid        = 1'b0;
   logic                           req_stall;
   rled_pkg::req_type              req_data         = '0;
   logic                           rsp_valid;
   logic                           rsp_stall        = 1'b0;
   rled_pkg::rsp_type              rsp_data;
   logic                           csr_write_enable = 1'b0;
   logic [rled_pkg::CLUSTER_W-1:0] csr_write_data   = '0;

   logic [rled_pkg::CLUSTER_W-1:0] cluster_size = rled_pkg::CLUSTER_RESET;
   parse_phase_type                parse_phase  = SEEK_HEADER;
   logic [3:0]                     len_size     = '0;
   logic [3:0]                     off_size     = '0;
   logic [3:0]                     byte_count   = '0;
   logic [63:0]                    len_acc      = '0;
   logic [63:0]                    delta_acc    = '0;
   logic [63:0]                    cluster_no   = '0;
   logic                           extent_seen  = 1'b0;

   rled_pkg::rsp_type expected_words [$];
   rled_pkg::req_type list_words [$];
   directed_row_type  directed_rows [$];
   int                sent_words     = 0;
   int                mismatch_count = 0;
   int                quiet_cycles   = 0;
   bit                steady_send    = 1'b0;

   run_list_extent_decoder DUT (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data,
      .csr_write_enable,
      .csr_write_data
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic rled_pkg::rsp_type status_word(rled_pkg::status_type st, logic last);
      rled_pkg::rsp_type w;
      w = '0;
      w.result_kind = rled_pkg::KIND_STATUS;
      w.status      = st;
      w.last_result = last;
      return w;
   endfunction

   function automatic rled_pkg::rsp_type extent_word(logic [63:0] off, logic [63:0] len,
                                                     logic last);
      rled_pkg::rsp_type w;
      w = '0;
      w.result_kind  = rled_pkg::KIND_EXTENT;
      w.disk_offset  = off;
      w.length_bytes = len;
      w.status       = rled_pkg::ST_OK;
      w.last_result  = last;
      return w;
   endfunction

   function automatic void clear_parser();
      parse_phase = SEEK_HEADER;
      len_size    = '0;
      off_size    = '0;
      byte_count  = '0;
      len_acc     = '0;
      delta_acc   = '0;
      cluster_no  = '0;
      extent_seen = 1'b0;
   endfunction

   function automatic rled_pkg::rsp_type close_list(rled_pkg::status_type st);
      parse_phase = LIST_DONE;
      return status_word(st, 1'b0);
   endfunction

   function automatic void decode_word(input rled_pkg::req_type w,
                                       output rled_pkg::rsp_type res [2], output int n);
      logic [63:0] scale;
      n      = 0;
      res[0] = '0;
      res[1] = '0;
      scale  = {42'd0, cluster_size};
      case (parse_phase)
         SEEK_HEADER: begin
            if (w.run_byte == 8'h00) begin
               res[0] = close_list(extent_seen ? rled_pkg::ST_OK : rled_pkg::ST_EMPTY);
               n = 1;
            end else if (w.run_byte[3:0] == 4'd0 ||
                         w.run_byte[3:0] > rled_pkg::MAX_FIELD_BYTES ||
                         w.run_byte[7:4] > rled_pkg::MAX_FIELD_BYTES) begin
               res[0] = close_list(rled_pkg::ST_BAD_HEADER);
               n = 1;
            end else if (w.last_byte) begin
               res[0] = close_list(rled_pkg::ST_TRUNCATED);
               n = 1;
            end else begin
               len_size    = w.run_byte[3:0];
               off_size    = w.run_byte[7:4];
               byte_count  = '0;
               len_acc     = '0;
               delta_acc   = '0;
               parse_phase = IN_LENGTH;
            end
         end
         IN_LENGTH: begin
            len_acc    = len_acc | ({56'd0, w.run_byte} << (8 * byte_count[2:0]));
            byte_count = byte_count + 4'd1;
            if (byte_count >= len_size) begin
               if (off_size == 4'd0) begin
                  res[0] = close_list(rled_pkg::ST_SPARSE);
                  n = 1;
               end else if (w.last_byte) begin
                  res[0] = close_list(rled_pkg::ST_TRUNCATED);
                  n = 1;
               end else begin
                  byte_count  = '0;
                  parse_phase = IN_OFFSET;
               end
            end else if (w.last_byte) begin
               res[0] = close_list(rled_pkg::ST_TRUNCATED);
               n = 1;
            end
         end
         IN_OFFSET: begin
            delta_acc  = delta_acc | ({56'd0, w.run_byte} << (8 * byte_count[2:0]));
            byte_count = byte_count + 4'd1;
            if (byte_count >= off_size) begin
               if (w.run_byte[7] && off_size < rled_pkg::MAX_FIELD_BYTES)
                  delta_acc = delta_acc | (~64'd0 << (8 * off_size));
               cluster_no = cluster_no + delta_acc;
               if (cluster_no[63]) begin
                  res[0] = close_list(rled_pkg::ST_NEGATIVE);
                  n = 1;
               end else begin
                  res[0]      = extent_word(cluster_no * scale, len_acc * scale, 1'b0);
                  n           = 1;
                  extent_seen = 1'b1;
                  byte_count  = '0;
                  parse_phase = SEEK_HEADER;
                  if (w.last_byte) begin
                     res[1] = close_list(rled_pkg::ST_OK);
                     n = 2;
                  end
               end
            end else if (w.last_byte) begin
               res[0] = close_list(rled_pkg::ST_TRUNCATED);
               n = 1;
            end
         end
         default: ;
      endcase
      if (n > 0)
         res[n-1].last_result = 1'b1;
      if (w.last_byte)
         clear_parser();
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic void add_row(logic [7:0] b, logic last, int typed,
                                   rled_pkg::rsp_type first = '0,
                                   rled_pkg::rsp_type second = '0);
      directed_row_type row;
      row.word   = rled_pkg::req_type'({b, last});
      row.typed  = typed;
      row.first  = first;
      row.second = second;
      directed_rows = {directed_rows, row};
   endfunction

   function automatic void push_byte(logic [7:0] b);
      list_words = {list_words, rled_pkg::req_type'({b, 1'b0})};
   endfunction

   function automatic void add_run();
      logic [3:0] ls;
      logic [3:0] os;
      logic [7:0] b;
      ls = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, rled_pkg::MAX_FIELD_BYTES))
                                       : 4'($urandom_range(1, 3));
      if ($urandom_range(0, 19) == 0)
         os = 4'd0;
      else if ($urandom_range(0, 3) == 0)
         os = 4'($urandom_range(1, rled_pkg::MAX_FIELD_BYTES));
      else
         os = 4'($urandom_range(1, 3));
      push_byte({os, ls});
      for (int i = 0; i < ls; i++)
         push_byte(8'($urandom));
      for (int i = 0; i < os; i++) begin
         b = 8'($urandom);
         if (i == os - 1 && $urandom_range(0, 9) < 8)
            b[7] = 1'b0;
         push_byte(b);
      end
   endfunction

   function automatic void build_list();
      int         style;
      logic [7:0] b;
      list_words.delete();
      style = $urandom_range(0, 99);
      if (style < 8) begin
         repeat ($urandom_range(1, 12)) push_byte(8'($urandom));
      end else begin
         repeat ($urandom_range(1, 5)) add_run();
         if (style < 50) begin
            push_byte(8'h00);
            repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
         end else if (style < 80) begin
         end else if (style < 90) begin
            repeat ($urandom_range(1, list_words.size() - 1)) void'(list_words.pop_back());
         end else begin
            case ($urandom_range(0, 2))
               0:       b = {4'($urandom), 4'd0};
               1:       b = {4'($urandom), 4'($urandom_range(9, 15))};
               default: b = {4'($urandom_range(9, 15)), 4'($urandom_range(1, 8))};
            endcase
            push_byte(b);
            repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
         end
      end
      list_words[list_words.size()-1].last_byte = 1'b1;
   endfunction

   task automatic send_word(input rled_pkg::req_type w, input int typed = -1,
                            input rled_pkg::rsp_type first = '0,
                            input rled_pkg::rsp_type second = '0);
      rled_pkg::rsp_type res [2];
      int                n;
      int                gap;
      gap = steady_send ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      sent_words++;
      decode_word(w, res, n);
      if (typed >= 0) begin
         n      = typed;
         res[0] = first;
         res[1] = second;
      end
      for (int i = 0; i < n; i++)
         expected_words = {expected_words, res[i]};
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_cluster(logic [rled_pkg::CLUSTER_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      cluster_size = value;
      csr_write_enable <= 1'b0;
   endtask

   task automatic check_result(rled_pkg::rsp_type got);
      rled_pkg::rsp_type want;
      if (expected_words.size() == 0) begin
         $error("unexpected result word: result_kind %0d status %0d",
                got.result_kind, got.status);
         mismatch_count++;
      end else begin
         want = expected_words.pop_front();
         if (got.result_kind !== want.result_kind) begin
            $error("result_kind expected %0d actual %0d", want.result_kind, got.result_kind);
            mismatch_count++;
         end
         if (got.disk_offset !== want.disk_offset) begin
            $error("disk_offset expected %h actual %h", want.disk_offset, got.disk_offset);
            mismatch_count++;
         end
         if (got.length_bytes !== want.length_bytes) begin
            $error("length_bytes expected %h actual %h", want.length_bytes, got.length_bytes);
            mismatch_count++;
         end
         if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            mismatch_count++;
         end
         if (got.last_result !== want.last_result) begin
            $error("last_result expected %0d actual %0d", want.last_result, got.last_result);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      bit hold_done;
      hold_done = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!hold_done && sent_words >= HOLD_AFTER) begin
            rsp_stall <= 1'b1;
            repeat (120) @(posedge clock);
            hold_done = 1'b1;
         end else if ($urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(20, 80)) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
            repeat (pick_gap() + 1) @(posedge clock);
         end
      end
   end

   initial begin
      logic [rled_pkg::CLUSTER_W-1:0] sizes [6];
      int                             phase_target;
      add_row(8'h00, 1'b0, 1, status_word(rled_pkg::ST_EMPTY, 1'b1));
      add_row(8'hAA, 1'b1, 0);
      add_row(8'h11, 1'b0, 0);
      add_row(8'h05, 1'b0, 0);
      add_row(8'h10, 1'b0, 1, extent_word(64'd65536, 64'd20480, 1'b1));
      add_row(8'h00, 1'b1, 1, status_word(rled_pkg::ST_OK, 1'b1));
      add_row(8'h09, 1'b1, 1, status_word(rled_pkg::ST_BAD_HEADER, 1'b1));
      add_row(8'h90, 1'b1, 1, status_word(rled_pkg::ST_BAD_HEADER, 1'b1));
      add_row(8'hFF, 1'b1, 1, status_word(rled_pkg::ST_BAD_HEADER, 1'b1));
      add_row(8'h11, 1'b1, 1, status_word(rled_pkg::ST_TRUNCATED, 1'b1));
      add_row(8'h01, 1'b0, 0);
      add_row(8'h07, 1'b1, 1, status_word(rled_pkg::ST_SPARSE, 1'b1));
      add_row(8'h11, 1'b0, 0);
      add_row(8'h01, 1'b0, 0);
      add_row(8'h80, 1'b1, 1, status_word(rled_pkg::ST_NEGATIVE, 1'b1));
      add_row(8'h81, 1'b0, -1);
      add_row(8'hFF, 1'b0, -1);
      repeat (7) add_row(8'hFF, 1'b0, -1);
      add_row(8'h7F, 1'b1, -1);

      sizes[0] = 22'd1;
      sizes[1] = 22'd2097152;
      sizes[2] = 22'($urandom_range(2, 2097151));
      sizes[3] = 22'd512;
      sizes[4] = 22'($urandom_range(2, 65535));
      sizes[5] = 22'd4096;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].typed,
                   directed_rows[i].first, directed_rows[i].second);

      for (int p = 0; p < 6; p++) begin
         settle();
         write_cluster(sizes[p]);
         phase_target = sent_words + PHASE_WORDS;
         while (sent_words < phase_target) begin
            build_list();
            steady_send = ($urandom_range(0, 4) == 0);
            foreach (list_words[i])
               send_word(list_words[i]);
         end
      end
      settle();

      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
